### hdl/scm_pkg.sv
// shared types, constants and color tables for the spectrogram color mapper
package scm_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int REG_W = 2;

  typedef logic [REG_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_MAP = 2'd0;
  localparam reg_idx_t REG_LOW = 2'd1;
  localparam reg_idx_t REG_HIGH = 2'd2;

  localparam int LIMIT_W = 16;
  localparam int SEL_W = 2;
  localparam int MAPS = 3;

  typedef logic [SEL_W-1:0] map_sel_t;

  localparam map_sel_t MAP_VIRIDIS = 2'd0;
  localparam map_sel_t MAP_INFERNO = 2'd1;
  localparam map_sel_t MAP_PLASMA = 2'd2;
  localparam map_sel_t MAP_UNUSED = 2'd3;

  localparam logic signed [LIMIT_W-1:0] HIGH_RESET = 16'sd256;

  typedef struct packed {
    map_sel_t map_select;
    logic signed [LIMIT_W-1:0] low_limit;
    logic signed [LIMIT_W-1:0] high_limit;
  } cfg_t;

  // normalized fraction: 16-bit numerator, 17-bit quotient up to 1.0
  localparam int NUM_W = 16;
  localparam int FRAC_W = 17;
  localparam int FRAC_SHIFT = 16;
  localparam int DIV_STEPS = 3;

  localparam int KNOTS = 9;
  localparam int KNOT_IDX_W = 4;
  localparam int SEG_W = 3;
  localparam int CHANNELS = 3;
  localparam int COLOR_W = 8;
  localparam int GAP_W = 14;
  localparam int PROD_W = 22;
  localparam int DSOR_W = 15;
  localparam int DVD_W = 23;

  typedef logic [COLOR_W-1:0] color_t;

  localparam logic [GAP_W-1:0] GAP_WIDE = 14'd8520;
  localparam logic [GAP_W-1:0] GAP_NARROW = 14'd7864;

  localparam logic [FRAC_W-1:0] KNOT_POS [KNOTS] = '{
    17'd0, 17'd8520, 17'd16384, 17'd24904, 17'd32768,
    17'd41288, 17'd49152, 17'd57672, 17'd65536
  };

  localparam color_t MAP_RGB [MAPS][KNOTS][CHANNELS] = '{
    '{ '{68, 1, 84}, '{71, 44, 122}, '{59, 81, 139}, '{44, 113, 142},
       '{33, 144, 140}, '{39, 173, 129}, '{92, 200, 99}, '{170, 220, 50},
       '{253, 231, 37} },
    '{ '{0, 0, 4}, '{31, 12, 72}, '{85, 15, 109}, '{136, 19, 97},
       '{186, 25, 51}, '{219, 51, 28}, '{232, 113, 32}, '{236, 173, 55},
       '{252, 255, 164} },
    '{ '{13, 8, 135}, '{84, 2, 163}, '{139, 10, 165}, '{185, 50, 137},
       '{219, 92, 104}, '{244, 136, 73}, '{254, 188, 43}, '{240, 249, 33},
       '{240, 249, 33} }
  };

endpackage

### hdl/scm_front.sv
// input stage: clamp to the window, numerator and span for normalization
module scm_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  scm_pkg::cfg_t cfg,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic out_valid,
  input  logic out_stall,
  output logic [scm_pkg::NUM_W-1:0] out_num,
  output logic [scm_pkg::NUM_W-1:0] out_span,
  output scm_pkg::map_sel_t out_sel
);

  localparam int CW = (SAMPLE_BITS > scm_pkg::LIMIT_W ? SAMPLE_BITS : scm_pkg::LIMIT_W) + 1;

  logic signed [CW-1:0] v_x;
  logic signed [CW-1:0] lo_x;
  logic signed [CW-1:0] hi_x;
  logic signed [CW-1:0] v_clamp;
  logic signed [CW-1:0] num_full;
  logic signed [CW-1:0] span_full;
  logic empty;
  logic adv;
  logic [scm_pkg::NUM_W-1:0] num_next;
  logic [scm_pkg::NUM_W-1:0] span_next;
  scm_pkg::map_sel_t sel_next;

  assign v_x = CW'(in_sample);
  assign lo_x = CW'(cfg.low_limit);
  assign hi_x = CW'(cfg.high_limit);
  assign empty = (hi_x <= lo_x);

  always_comb begin
    if (v_x < lo_x) begin
      v_clamp = lo_x;
    end else if (v_x > hi_x) begin
      v_clamp = hi_x;
    end else begin
      v_clamp = v_x;
    end
    num_full = v_clamp - lo_x;
    span_full = hi_x - lo_x;
    // empty window: zero over one gives the first knot
    if (empty) begin
      num_next = '0;
      span_next = scm_pkg::NUM_W'(1);
    end else begin
      num_next = num_full[scm_pkg::NUM_W-1:0];
      span_next = span_full[scm_pkg::NUM_W-1:0];
    end
    if (cfg.map_select == scm_pkg::MAP_UNUSED) begin
      sel_next = scm_pkg::MAP_VIRIDIS;
    end else begin
      sel_next = cfg.map_select;
    end
  end

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_num <= num_next;
      out_span <= span_next;
      out_sel <= sel_next;
    end
  end

endmodule

### hdl/scm_div.sv
// pipelined restoring divider, several quotient bits per stage, shared divisor
module scm_div #(
  parameter int DW = 16,
  parameter int QW = 17,
  parameter int LANES = 1,
  parameter int STEPS = 3,
  parameter int PW = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [DW-1:0] in_div,
  input  logic [LANES-1:0][DW+QW-1:0] in_dvd,
  input  logic [PW-1:0] in_pay,
  output logic out_valid,
  input  logic out_stall,
  output logic [LANES-1:0][QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  localparam int NS = (QW + STEPS - 1) / STEPS;

  logic [NS-1:0] vld;
  logic [NS:0] adv;
  logic [NS-1:0][DW-1:0] dvs;
  logic [NS-1:0][LANES-1:0][DW-1:0] rem;
  logic [NS-1:0][LANES-1:0][QW-1:0] low;
  logic [NS-1:0][PW-1:0] pay;

  assign adv[NS] = !out_stall;
  assign in_stall = !adv[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic src_vld;
    logic [DW-1:0] src_dvs;
    logic [LANES-1:0][DW-1:0] src_rem;
    logic [LANES-1:0][QW-1:0] src_low;
    logic [PW-1:0] src_pay;
    logic [LANES-1:0][DW-1:0] rem_next;
    logic [LANES-1:0][QW-1:0] low_next;

    if (s == 0) begin : g_first
      always_comb begin
        src_vld = in_valid;
        src_dvs = in_div;
        src_pay = in_pay;
        for (int l = 0; l < LANES; l++) begin
          src_rem[l] = in_dvd[l][DW+QW-1:QW];
          src_low[l] = in_dvd[l][QW-1:0];
        end
      end
    end else begin : g_rest
      always_comb begin
        src_vld = vld[s-1];
        src_dvs = dvs[s-1];
        src_pay = pay[s-1];
        src_rem = rem[s-1];
        src_low = low[s-1];
      end
    end

    // low word shifts dividend bits out at the top and quotient bits in at the bottom
    always_comb begin
      logic [DW+1:0] trial;
      rem_next = src_rem;
      low_next = src_low;
      trial = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < QW) begin
          for (int l = 0; l < LANES; l++) begin
            trial = {1'b0, rem_next[l], low_next[l][QW-1]} - {2'b00, src_dvs};
            if (!trial[DW+1]) begin
              rem_next[l] = trial[DW-1:0];
              low_next[l] = {low_next[l][QW-2:0], 1'b1};
            end else begin
              rem_next[l] = {rem_next[l][DW-2:0], low_next[l][QW-1]};
              low_next[l] = {low_next[l][QW-2:0], 1'b0};
            end
          end
        end
      end
    end

    assign adv[s] = !vld[s] || adv[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv[s]) begin
        vld[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        dvs[s] <= src_dvs;
        rem[s] <= rem_next;
        low[s] <= low_next;
        pay[s] <= src_pay;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_quo = low[NS-1];
  assign out_pay = pay[NS-1];

endmodule

### hdl/scm_interp.sv
// segment search, knot color lookup and interpolation products
module scm_interp (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [scm_pkg::FRAC_W-1:0] in_u,
  input  scm_pkg::map_sel_t in_sel,
  output logic out_valid,
  input  logic out_stall,
  output logic [scm_pkg::DSOR_W-1:0] out_dsor,
  output logic [scm_pkg::CHANNELS-1:0][scm_pkg::DVD_W-1:0] out_dvd
);

  logic adv_a;
  logic adv_b;
  logic adv_c;
  logic a_vld;
  logic b_vld;

  logic [scm_pkg::SEG_W-1:0] seg;
  logic [scm_pkg::KNOT_IDX_W-1:0] seg_lo;
  logic [scm_pkg::KNOT_IDX_W-1:0] seg_hi;
  logic [scm_pkg::GAP_W-1:0] d_next;
  logic [scm_pkg::GAP_W-1:0] e_next;
  scm_pkg::color_t [scm_pkg::CHANNELS-1:0] c0_next;
  scm_pkg::color_t [scm_pkg::CHANNELS-1:0] c1_next;

  scm_pkg::color_t [scm_pkg::CHANNELS-1:0] a_c0;
  scm_pkg::color_t [scm_pkg::CHANNELS-1:0] a_c1;
  logic [scm_pkg::GAP_W-1:0] a_d;
  logic [scm_pkg::GAP_W-1:0] a_e;

  logic [scm_pkg::GAP_W-1:0] a_rest;
  logic [scm_pkg::CHANNELS-1:0][scm_pkg::PROD_W-1:0] p0_next;
  logic [scm_pkg::CHANNELS-1:0][scm_pkg::PROD_W-1:0] p1_next;
  logic [scm_pkg::CHANNELS-1:0][scm_pkg::PROD_W-1:0] b_p0;
  logic [scm_pkg::CHANNELS-1:0][scm_pkg::PROD_W-1:0] b_p1;
  logic [scm_pkg::GAP_W-1:0] b_d;

  logic [scm_pkg::CHANNELS-1:0][scm_pkg::DVD_W-1:0] dvd_next;

  // first segment whose upper knot is at or above u
  always_comb begin
    seg = '0;
    for (int k = 1; k < scm_pkg::KNOTS - 1; k++) begin
      if (in_u > scm_pkg::KNOT_POS[k]) begin
        seg = scm_pkg::SEG_W'(k);
      end
    end
    seg_lo = {1'b0, seg};
    seg_hi = seg_lo + 4'd1;
    d_next = scm_pkg::GAP_W'(scm_pkg::KNOT_POS[seg_hi] - scm_pkg::KNOT_POS[seg_lo]);
    e_next = scm_pkg::GAP_W'(in_u - scm_pkg::KNOT_POS[seg_lo]);
    for (int ch = 0; ch < scm_pkg::CHANNELS; ch++) begin
      c0_next[ch] = scm_pkg::MAP_RGB[in_sel][seg_lo][ch];
      c1_next[ch] = scm_pkg::MAP_RGB[in_sel][seg_hi][ch];
    end
  end

  assign a_rest = a_d - a_e;

  always_comb begin
    for (int ch = 0; ch < scm_pkg::CHANNELS; ch++) begin
      p0_next[ch] = scm_pkg::PROD_W'(a_c0[ch]) * scm_pkg::PROD_W'(a_rest);
      p1_next[ch] = scm_pkg::PROD_W'(a_c1[ch]) * scm_pkg::PROD_W'(a_e);
    end
  end

  // rounding numerator 2*acc + d over divisor 2*d
  always_comb begin
    for (int ch = 0; ch < scm_pkg::CHANNELS; ch++) begin
      dvd_next[ch] = {b_p0[ch] + b_p1[ch], 1'b0} + scm_pkg::DVD_W'(b_d);
    end
  end

  assign adv_c = !out_valid || !out_stall;
  assign adv_b = !b_vld || adv_c;
  assign adv_a = !a_vld || adv_b;
  assign in_stall = !adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        a_vld <= in_valid;
      end
      if (adv_b) begin
        b_vld <= a_vld;
      end
      if (adv_c) begin
        out_valid <= b_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_c0 <= c0_next;
      a_c1 <= c1_next;
      a_d <= d_next;
      a_e <= e_next;
    end
    if (adv_b) begin
      b_p0 <= p0_next;
      b_p1 <= p1_next;
      b_d <= a_d;
    end
    if (adv_c) begin
      out_dvd <= dvd_next;
      out_dsor <= {b_d, 1'b0};
    end
  end

endmodule

### hdl/spectrogram_colormap.sv
// Spectrogram color mapper: clamps a signed Q8.8 sample to the configured window,
// normalizes it to a 17-bit fraction and interpolates red, green and blue between
// nine knots of the viridis, inferno or plasma map. The block takes one item per
// cycle while sample_stall is low and passes it through 13 register stages: one
// clamp stage, six stages of the normalizing divider (17 quotient bits at three
// bits per stage), three interpolation stages (lookup, multiply, sum) and three
// stages of the rounding divider (8 quotient bits). Bubbles close up as items
// move on, so the input stalls only when every stage holds an item and the
// output is stalled. Registers: map_select at 0x0, low_limit at 0x4, high_limit
// at 0x8; the user must see that they are written only while no item is in
// flight, since the block itself does not enforce it.
module spectrogram_colormap #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [scm_pkg::ADDR_W-1:0] paddr,
  input  logic [scm_pkg::DATA_W-1:0] pwdata,
  output logic [scm_pkg::DATA_W-1:0] prdata,
  output logic pready,
  input  logic sample_valid,
  output logic sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  output logic color_valid,
  input  logic color_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  scm_pkg::cfg_t cfg;
  scm_pkg::reg_idx_t reg_idx;
  logic wr_en;

  logic f_valid;
  logic f_stall;
  logic [scm_pkg::NUM_W-1:0] f_num;
  logic [scm_pkg::NUM_W-1:0] f_span;
  scm_pkg::map_sel_t f_sel;
  logic [0:0][scm_pkg::NUM_W+scm_pkg::FRAC_W-1:0] f_dvd;

  logic u_valid;
  logic u_stall;
  logic [0:0][scm_pkg::FRAC_W-1:0] u_quo;
  scm_pkg::map_sel_t u_sel;

  logic iv_valid;
  logic iv_stall;
  logic [scm_pkg::DSOR_W-1:0] iv_dsor;
  logic [scm_pkg::CHANNELS-1:0][scm_pkg::DVD_W-1:0] iv_dvd;

  logic [scm_pkg::CHANNELS-1:0][scm_pkg::COLOR_W-1:0] rgb;

  assign pready = 1'b1;
  assign reg_idx = paddr[scm_pkg::ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_select <= scm_pkg::MAP_VIRIDIS;
      cfg.low_limit <= '0;
      cfg.high_limit <= scm_pkg::HIGH_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        scm_pkg::REG_MAP: begin
          cfg.map_select <= pwdata[scm_pkg::SEL_W-1:0];
        end
        scm_pkg::REG_LOW: begin
          cfg.low_limit <= pwdata[scm_pkg::LIMIT_W-1:0];
        end
        scm_pkg::REG_HIGH: begin
          cfg.high_limit <= pwdata[scm_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      scm_pkg::REG_MAP: begin
        prdata = scm_pkg::DATA_W'(cfg.map_select);
      end
      scm_pkg::REG_LOW: begin
        prdata = scm_pkg::DATA_W'(cfg.low_limit);
      end
      scm_pkg::REG_HIGH: begin
        prdata = scm_pkg::DATA_W'(cfg.high_limit);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  scm_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(sample_valid),
    .in_stall(sample_stall),
    .in_sample(sample_value),
    .out_valid(f_valid),
    .out_stall(f_stall),
    .out_num(f_num),
    .out_span(f_span),
    .out_sel(f_sel)
  );

  // u = num * 65536 / span
  assign f_dvd[0] = {1'b0, f_num, {scm_pkg::FRAC_SHIFT{1'b0}}};

  scm_div #(
    .DW(scm_pkg::NUM_W),
    .QW(scm_pkg::FRAC_W),
    .LANES(1),
    .STEPS(scm_pkg::DIV_STEPS),
    .PW(scm_pkg::SEL_W)
  ) u_norm_div (
    .clk(clk),
    .rst(rst),
    .in_valid(f_valid),
    .in_stall(f_stall),
    .in_div(f_span),
    .in_dvd(f_dvd),
    .in_pay(f_sel),
    .out_valid(u_valid),
    .out_stall(u_stall),
    .out_quo(u_quo),
    .out_pay(u_sel)
  );

  scm_interp u_interp (
    .clk(clk),
    .rst(rst),
    .in_valid(u_valid),
    .in_stall(u_stall),
    .in_u(u_quo[0]),
    .in_sel(u_sel),
    .out_valid(iv_valid),
    .out_stall(iv_stall),
    .out_dsor(iv_dsor),
    .out_dvd(iv_dvd)
  );

  scm_div #(
    .DW(scm_pkg::DSOR_W),
    .QW(scm_pkg::COLOR_W),
    .LANES(scm_pkg::CHANNELS),
    .STEPS(scm_pkg::DIV_STEPS),
    .PW(1)
  ) u_round_div (
    .clk(clk),
    .rst(rst),
    .in_valid(iv_valid),
    .in_stall(iv_stall),
    .in_div(iv_dsor),
    .in_dvd(iv_dvd),
    .in_pay(1'b0),
    .out_valid(color_valid),
    .out_stall(color_stall),
    .out_quo(rgb),
    .out_pay()
  );

  assign red = rgb[0];
  assign green = rgb[1];
  assign blue = rgb[2];

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> color_valid && color_stall)
    else $error("input stalled while the output side was free");

  a_frac_in_range: assert property (@(posedge clk) disable iff (rst)
    u_valid |-> u_quo[0] <= scm_pkg::KNOT_POS[scm_pkg::KNOTS-1])
    else $error("normalized fraction above one");

  a_knot_gap: assert property (@(posedge clk) disable iff (rst)
    iv_valid |-> (iv_dsor == {scm_pkg::GAP_WIDE, 1'b0}) ||
                 (iv_dsor == {scm_pkg::GAP_NARROW, 1'b0}))
    else $error("rounding divisor is not a knot gap");

endmodule
